FILE: rtl/obstacle_turn_decider_with_loop_memory_top_defines.svh
// Assertion macros for the obstacle turn decider
`ifndef OBSTACLE_TURN_DECIDER_WITH_LOOP_MEMORY_TOP_DEFINES_SVH
`define OBSTACLE_TURN_DECIDER_WITH_LOOP_MEMORY_TOP_DEFINES_SVH

// same-cycle implication
`define OTD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("otd assertion failed");

// next-cycle implication
`define OTD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("otd assertion failed");

`endif

FILE: rtl/otd_pkg.sv
// Shared types, constants and functions of the obstacle turn decider
`timescale 1ns / 1ps
package otd_pkg;

   localparam int HISTORY_DEPTH = 16;
   localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

   localparam int RANGE_W  = 10;
   localparam int SUM_W    = RANGE_W + 1;
   localparam int POS_W    = 16;
   localparam int HEAD_W   = 12;
   localparam int DIST_W   = 10;
   localparam int TIE_W    = 9;
   localparam int RADIUS_W = 12;
   localparam int TOL_W    = 11;
   localparam int SPEED_W  = 7;
   localparam int STEER_W  = 2;
   localparam int REASON_W = 3;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_OBSTACLE_TRIGGER = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CORNER_DIVERGENCE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIE_FRACTION = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_RADIUS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_HEADING_TOL = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CRUISE_SPEED = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DECISION_SPEED = 3'd6;

   localparam logic [STEER_W-1:0] STEER_STRAIGHT = 2'd0;
   localparam logic [STEER_W-1:0] STEER_LEFT     = 2'd1;
   localparam logic [STEER_W-1:0] STEER_RIGHT    = 2'd2;

   localparam logic [REASON_W-1:0] REASON_CRUISE     = 3'd0;
   localparam logic [REASON_W-1:0] REASON_TIE        = 3'd1;
   localparam logic [REASON_W-1:0] REASON_MORE_LEFT  = 3'd2;
   localparam logic [REASON_W-1:0] REASON_MORE_RIGHT = 3'd3;
   localparam logic [REASON_W-1:0] REASON_LOOP       = 3'd4;

   // full turn and half turn in tenths of a degree
   localparam logic [HEAD_W-1:0] HEADING_FULL = HEAD_W'(3600);
   localparam logic [HEAD_W-1:0] HEADING_HALF = HEAD_W'(1800);

   localparam logic [CNT_W:0]   DEPTH_X = (CNT_W + 1)'(HISTORY_DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(HISTORY_DEPTH);

   typedef struct packed {
      logic [RANGE_W-1:0] front_cm;
      logic               ir_front;
      logic [RANGE_W-1:0] left45_cm;
      logic [RANGE_W-1:0] left90_cm;
      logic [RANGE_W-1:0] right45_cm;
      logic [RANGE_W-1:0] right90_cm;
      logic [POS_W-1:0]   pos_x_cm;
      logic [POS_W-1:0]   pos_y_cm;
      logic [HEAD_W-1:0]  heading_tenths;
      logic               coin_bit;
   } otd_req_type;

   typedef struct packed {
      logic [SPEED_W-1:0]  speed_pct;
      logic [STEER_W-1:0]  steer_dir;
      logic                in_decision;
      logic [REASON_W-1:0] reason_code;
   } otd_rsp_type;

   typedef struct packed {
      logic [POS_W-1:0]   x;
      logic [POS_W-1:0]   y;
      logic [HEAD_W-1:0]  heading;
      logic [STEER_W-1:0] turn;
   } otd_entry_type;

   typedef struct packed {
      logic load;
      logic classify;
      logic read;
      logic mul;
      logic check;
      logic append;
      logic emit;
   } otd_cmd_type;

   typedef struct packed {
      logic decide;
      logic count_zero;
      logic count_full;
      logic match;
      logic last;
      logic out_busy;
   } otd_sts_type;

   function automatic logic [HEAD_W-1:0] heading_diff(input logic [HEAD_W-1:0] a,
                                                      input logic [HEAD_W-1:0] b);
      logic [HEAD_W-1:0] d;
      d = (a > b) ? a - b : b - a;
      if (d >= HEADING_FULL) d = d - HEADING_FULL;
      if (d > HEADING_HALF) d = HEADING_FULL - d;
      return d;
   endfunction

   function automatic logic [STEER_W-1:0] opposite_turn(input logic [STEER_W-1:0] t);
      logic [STEER_W-1:0] r;
      case (t)
         STEER_LEFT:  r = STEER_RIGHT;
         STEER_RIGHT: r = STEER_LEFT;
         default:     r = STEER_STRAIGHT;
      endcase
      return r;
   endfunction

   function automatic logic [IDX_W-1:0] wrap_idx(input logic [CNT_W:0] s);
      logic [CNT_W:0] t;
      t = (s >= DEPTH_X) ? s - DEPTH_X : s;
      return t[IDX_W-1:0];
   endfunction

endpackage

FILE: rtl/otd_intf.sv
// Scan request and steering response channel interfaces
`timescale 1ns / 1ps
interface otd_req_if;
   import otd_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [RANGE_W-1:0]       front_cm;
   logic                     ir_front;
   logic [RANGE_W-1:0]       left45_cm;
   logic [RANGE_W-1:0]       left90_cm;
   logic [RANGE_W-1:0]       right45_cm;
   logic [RANGE_W-1:0]       right90_cm;
   logic signed [POS_W-1:0]  pos_x_cm;
   logic signed [POS_W-1:0]  pos_y_cm;
   logic [HEAD_W-1:0]        heading_tenths;
   logic                     coin_bit;

   modport source (output valid, front_cm, ir_front, left45_cm, left90_cm, right45_cm,
                   right90_cm, pos_x_cm, pos_y_cm, heading_tenths, coin_bit,
                   input ready);
   modport sink (input valid, front_cm, ir_front, left45_cm, left90_cm, right45_cm,
                 right90_cm, pos_x_cm, pos_y_cm, heading_tenths, coin_bit,
                 output ready);
endinterface

interface otd_rsp_if;
   import otd_pkg::*;
   logic                valid;
   logic                ready;
   logic [SPEED_W-1:0]  speed_pct;
   logic [STEER_W-1:0]  steer_dir;
   logic                in_decision;
   logic [REASON_W-1:0] reason_code;

   modport source (output valid, speed_pct, steer_dir, in_decision, reason_code,
                   input ready);
   modport sink (input valid, speed_pct, steer_dir, in_decision, reason_code,
                 output ready);
endinterface

FILE: rtl/otd_dp.sv
// Datapath: registers, side choice, history memory search and result register
`timescale 1ns / 1ps
module otd_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  otd_pkg::otd_cmd_type               cmd,
   output otd_pkg::otd_sts_type               sts,
   input  otd_pkg::otd_req_type               req,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output otd_pkg::otd_rsp_type               rsp,
   input  logic                               csr_wr_en,
   input  logic [otd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [otd_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import otd_pkg::*;

   logic [DIST_W-1:0]   trig_ff;
   logic [DIST_W-1:0]   corner_ff;
   logic [TIE_W-1:0]    tie_ff;
   logic [RADIUS_W-1:0] radius_ff;
   logic [TOL_W-1:0]    tol_ff;
   logic [SPEED_W-1:0]  cruise_ff;
   logic [SPEED_W-1:0]  dspeed_ff;

   otd_req_type   in_ff;
   logic          decide_ff;
   logic          decide_in;
   logic [RANGE_W-1:0] div;

   logic [SUM_W-1:0]          lsum;
   logic [SUM_W-1:0]          rsum;
   logic [SUM_W-1:0]          larger;
   logic [SUM_W-1:0]          diff;
   logic [TIE_W+SUM_W-1:0]    tie_lhs;
   logic [TIE_W+SUM_W-1:0]    tie_rhs;
   logic                      is_tie;
   logic [STEER_W-1:0]        turn_in;
   logic [REASON_W-1:0]       reason_in;
   logic [STEER_W-1:0]        turn_ff;
   logic [REASON_W-1:0]       reason_ff;
   logic [2*RADIUS_W-1:0]     r2_ff;

   otd_entry_type      mem [HISTORY_DEPTH];
   otd_entry_type      rd_q_ff;
   logic [IDX_W-1:0]   rd_idx;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic [CNT_W-1:0]   k_ff;
   logic [CNT_W-1:0]   k_plus;
   logic [IDX_W-1:0]   oldest_ff;
   logic [IDX_W-1:0]   oldest_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic [IDX_W-1:0]   slot;

   logic signed [POS_W:0] dx;
   logic signed [POS_W:0] dy;
   logic [POS_W:0]        adx;
   logic [POS_W:0]        ady;
   logic [2*POS_W-1:0]    sqx_ff;
   logic [2*POS_W-1:0]    sqy_ff;
   logic                  hd_ok_ff;
   logic [2*POS_W:0]      dist_sq;
   logic                  match;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   otd_entry_type      wr_data;

   logic               rsp_valid_ff;
   otd_rsp_type        rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_ff   <= DIST_W'(30);
         corner_ff <= DIST_W'(50);
         tie_ff    <= TIE_W'(26);
         radius_ff <= RADIUS_W'(40);
         tol_ff    <= TOL_W'(300);
         cruise_ff <= SPEED_W'(60);
         dspeed_ff <= SPEED_W'(30);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_OBSTACLE_TRIGGER:  trig_ff   <= csr_wdata[DIST_W-1:0];
            CSR_CORNER_DIVERGENCE: corner_ff <= csr_wdata[DIST_W-1:0];
            CSR_TIE_FRACTION:      tie_ff    <= csr_wdata[TIE_W-1:0];
            CSR_LOOP_RADIUS:       radius_ff <= csr_wdata[RADIUS_W-1:0];
            CSR_LOOP_HEADING_TOL:  tol_ff    <= csr_wdata[TOL_W-1:0];
            CSR_CRUISE_SPEED:      cruise_ff <= csr_wdata[SPEED_W-1:0];
            CSR_DECISION_SPEED:    dspeed_ff <= csr_wdata[SPEED_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      div = (req.left90_cm > req.right90_cm) ? req.left90_cm - req.right90_cm
                                             : req.right90_cm - req.left90_cm;
      decide_in = (req.front_cm <= trig_ff) || req.ir_front || (div >= corner_ff);
   end

   always_comb begin
      lsum    = SUM_W'(in_ff.left45_cm) + SUM_W'(in_ff.left90_cm);
      rsum    = SUM_W'(in_ff.right45_cm) + SUM_W'(in_ff.right90_cm);
      larger  = (lsum > rsum) ? lsum : rsum;
      diff    = (lsum > rsum) ? lsum - rsum : rsum - lsum;
      tie_lhs = {1'b0, diff, 8'h00};
      tie_rhs = tie_ff * larger;
      is_tie  = (larger != '0) && (tie_lhs <= tie_rhs);
      if (is_tie) begin
         turn_in   = in_ff.coin_bit ? STEER_RIGHT : STEER_LEFT;
         reason_in = REASON_TIE;
      end else if (lsum > rsum) begin
         turn_in   = STEER_LEFT;
         reason_in = REASON_MORE_LEFT;
      end else begin
         turn_in   = STEER_RIGHT;
         reason_in = REASON_MORE_RIGHT;
      end
   end

   always_comb begin
      rd_idx  = wrap_idx((CNT_W + 1)'(oldest_ff) + (CNT_W + 1)'(k_ff));
      k_plus  = k_ff + 1'b1;
      dx      = $signed({in_ff.pos_x_cm[POS_W-1], in_ff.pos_x_cm})
              - $signed({rd_q_ff.x[POS_W-1], rd_q_ff.x});
      dy      = $signed({in_ff.pos_y_cm[POS_W-1], in_ff.pos_y_cm})
              - $signed({rd_q_ff.y[POS_W-1], rd_q_ff.y});
      adx     = dx[POS_W] ? -dx : dx;
      ady     = dy[POS_W] ? -dy : dy;
      dist_sq = (2*POS_W + 1)'(sqx_ff) + (2*POS_W + 1)'(sqy_ff);
      match   = hd_ok_ff && (dist_sq <= (2*POS_W + 1)'(r2_ff));
   end

   always_comb begin
      if (count_ff == DEPTH_C) begin
         slot      = oldest_ff;
         oldest_in = wrap_idx((CNT_W + 1)'(oldest_ff) + (CNT_W + 1)'(1));
         count_in  = count_ff;
      end else begin
         slot      = wrap_idx((CNT_W + 1)'(oldest_ff) + (CNT_W + 1)'(count_ff));
         oldest_in = oldest_ff;
         count_in  = count_ff + 1'b1;
      end
   end

   always_comb begin
      wr_en           = (cmd.check && match) || cmd.append;
      wr_addr         = cmd.append ? slot : rd_idx_ff;
      wr_data.x       = in_ff.pos_x_cm;
      wr_data.y       = in_ff.pos_y_cm;
      wr_data.heading = in_ff.heading_tenths;
      wr_data.turn    = cmd.append ? turn_ff : opposite_turn(rd_q_ff.turn);
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (cmd.read) begin
         rd_q_ff   <= mem[rd_idx];
         rd_idx_ff <= rd_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) in_ff <= req;
      if (cmd.classify) r2_ff <= radius_ff * radius_ff;
      if (cmd.mul) begin
         sqx_ff   <= adx[POS_W-1:0] * adx[POS_W-1:0];
         sqy_ff   <= ady[POS_W-1:0] * ady[POS_W-1:0];
         hd_ok_ff <= heading_diff(in_ff.heading_tenths, rd_q_ff.heading)
                     <= HEAD_W'(tol_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decide_ff    <= 1'b0;
         turn_ff      <= STEER_STRAIGHT;
         reason_ff    <= REASON_CRUISE;
         k_ff         <= '0;
         oldest_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) decide_ff <= decide_in;
         if (cmd.classify) begin
            turn_ff   <= turn_in;
            reason_ff <= reason_in;
            k_ff      <= '0;
         end
         if (cmd.check) begin
            if (match) begin
               turn_ff   <= opposite_turn(rd_q_ff.turn);
               reason_ff <= REASON_LOOP;
            end else begin
               k_ff <= k_plus;
            end
         end
         if (cmd.append) begin
            oldest_ff <= oldest_in;
            count_ff  <= count_in;
         end
         if (cmd.emit) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         if (decide_ff) begin
            rsp_ff.speed_pct   <= dspeed_ff;
            rsp_ff.steer_dir   <= turn_ff;
            rsp_ff.in_decision <= 1'b1;
            rsp_ff.reason_code <= reason_ff;
         end else begin
            rsp_ff.speed_pct   <= cruise_ff;
            rsp_ff.steer_dir   <= STEER_STRAIGHT;
            rsp_ff.in_decision <= 1'b0;
            rsp_ff.reason_code <= REASON_CRUISE;
         end
      end
   end

   always_comb begin
      sts.decide     = decide_ff;
      sts.count_zero = (count_ff == '0);
      sts.count_full = (count_ff == DEPTH_C);
      sts.match      = match;
      sts.last       = (k_plus == count_ff);
      sts.out_busy   = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

FILE: rtl/otd_ctrl.sv
// Controller: sequences accept, classify, history search, append and emit
`timescale 1ns / 1ps
module otd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  otd_pkg::otd_sts_type  sts,
   output otd_pkg::otd_cmd_type  cmd
);
   import otd_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CLASS,
      S_READ,
      S_MUL,
      S_CHECK,
      S_APPEND,
      S_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CLASS;
            end
         end
         S_CLASS: begin
            cmd.classify = 1'b1;
            if (!sts.decide) state_in = S_FINISH;
            else if (sts.count_zero) state_in = S_APPEND;
            else state_in = S_READ;
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            if (sts.match) state_in = S_FINISH;
            else if (sts.last) state_in = S_APPEND;
            else state_in = S_READ;
         end
         S_APPEND: begin
            cmd.append = 1'b1;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            if (!sts.out_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule

FILE: rtl/obstacle_turn_decider_with_loop_memory_top.sv
// Obstacle turn decider with loop memory: top level
//
// One scan in, one steering transaction out. A scan with no obstacle ahead and no
// corner gives the cruise result; otherwise the side with more room is picked (the
// coin bit settles a near tie) and up to HISTORY_DEPTH (16) earlier decision poses
// are searched oldest first, each entry by memory read, squaring and compare;
// a matching pose forces the opposite turn and is overwritten, else the pose is
// appended, dropping the oldest when full. A cruising scan is accepted, classified
// and emitted; a decision first searches or appends to the history, whose serial
// search sets how long a scan occupies the block. The next scan is taken while a
// finished result waits on rsp_if. Configuration is written through csr_wr_en /
// csr_index / csr_wdata, by the user only while idle; the block does not enforce it.
`timescale 1ns / 1ps
`include "obstacle_turn_decider_with_loop_memory_top_defines.svh"
module obstacle_turn_decider_with_loop_memory_top (
   input  logic                            clock,
   input  logic                            reset,
   otd_req_if.sink                         req_if,
   otd_rsp_if.source                       rsp_if,
   input  logic                            csr_wr_en,
   input  logic [otd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [otd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import otd_pkg::*;

   otd_cmd_type cmd;
   otd_sts_type sts;
   otd_req_type req;
   otd_rsp_type rsp;
   logic        req_ready;
   logic        rsp_valid;

   always_comb begin
      req.front_cm       = req_if.front_cm;
      req.ir_front       = req_if.ir_front;
      req.left45_cm      = req_if.left45_cm;
      req.left90_cm      = req_if.left90_cm;
      req.right45_cm     = req_if.right45_cm;
      req.right90_cm     = req_if.right90_cm;
      req.pos_x_cm       = req_if.pos_x_cm;
      req.pos_y_cm       = req_if.pos_y_cm;
      req.heading_tenths = req_if.heading_tenths;
      req.coin_bit       = req_if.coin_bit;
   end

   otd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   otd_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req       (req),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   assign req_if.ready       = req_ready;
   assign rsp_if.valid       = rsp_valid;
   assign rsp_if.speed_pct   = rsp.speed_pct;
   assign rsp_if.steer_dir   = rsp.steer_dir;
   assign rsp_if.in_decision = rsp.in_decision;
   assign rsp_if.reason_code = rsp.reason_code;

   `OTD_ASSERT_NEXT(a_accept_busies, clock, reset, req_if.valid && req_ready, !req_ready)
   `OTD_ASSERT_NEXT(a_emit_shows_result, clock, reset, cmd.emit, rsp_if.valid)
   `OTD_ASSERT_NEXT(a_full_stays_full, clock, reset, sts.count_full, sts.count_full)
   `OTD_ASSERT_IMPL(a_check_has_entries, clock, reset, cmd.check, !sts.count_zero)

endmodule

FILE: tb/sv/otd_steer_check.sv
// Steering predictor and response comparison for the obstacle turn decider
`timescale 1ns / 1ps
module otd_steer_check (
   input  logic                            clock,
   input  logic                            reset,
   otd_req_if                              req_if,
   otd_rsp_if                              rsp_if,
   input  logic                            csr_wr_en,
   input  logic [otd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [otd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              pending,
   output int                              mismatch_count,
   output int                              results_seen,
   output int                              decisions_seen,
   output int                              ties_seen,
   output int                              loop_turns_seen
);
   import otd_pkg::*;

   logic [DIST_W-1:0]   cfg_trigger;
   logic [DIST_W-1:0]   cfg_corner;
   logic [TIE_W-1:0]    cfg_tie;
   logic [RADIUS_W-1:0] cfg_radius;
   logic [TOL_W-1:0]    cfg_tol;
   logic [SPEED_W-1:0]  cfg_cruise;
   logic [SPEED_W-1:0]  cfg_decision;

   logic [POS_W-1:0]    hist_x [HISTORY_DEPTH];
   logic [POS_W-1:0]    hist_y [HISTORY_DEPTH];
   logic [HEAD_W-1:0]   hist_heading [HISTORY_DEPTH];
   logic [STEER_W-1:0]  hist_turn [HISTORY_DEPTH];
   int unsigned         hist_oldest;
   int unsigned         hist_count;

   otd_rsp_type         steering_q [$];

   function automatic otd_rsp_type predict_steering(input otd_req_type s);
      otd_rsp_type         r;
      int unsigned         spread, lsum, rsum, larger, gap, hgap, idx, slot;
      logic [STEER_W-1:0]  turn;
      logic [REASON_W-1:0] reason;
      longint              dx, dy;
      bit                  hit;
      spread = (s.left90_cm > s.right90_cm) ? s.left90_cm - s.right90_cm
                                            : s.right90_cm - s.left90_cm;
      if (!(s.front_cm <= cfg_trigger || s.ir_front || spread >= cfg_corner)) begin
         r.speed_pct   = cfg_cruise;
         r.steer_dir   = STEER_STRAIGHT;
         r.in_decision = 1'b0;
         r.reason_code = REASON_CRUISE;
         return r;
      end
      lsum   = s.left45_cm + s.left90_cm;
      rsum   = s.right45_cm + s.right90_cm;
      larger = (lsum > rsum) ? lsum : rsum;
      gap    = (lsum > rsum) ? lsum - rsum : rsum - lsum;
      if (larger > 0 && gap * 256 <= cfg_tie * larger) begin
         turn   = s.coin_bit ? STEER_RIGHT : STEER_LEFT;
         reason = REASON_TIE;
      end else if (lsum > rsum) begin
         turn   = STEER_LEFT;
         reason = REASON_MORE_LEFT;
      end else begin
         turn   = STEER_RIGHT;
         reason = REASON_MORE_RIGHT;
      end
      hit = 1'b0;
      for (int unsigned k = 0; k < hist_count && !hit; k++) begin
         idx  = (hist_oldest + k) % HISTORY_DEPTH;
         dx   = longint'($signed(s.pos_x_cm)) - longint'($signed(hist_x[idx]));
         dy   = longint'($signed(s.pos_y_cm)) - longint'($signed(hist_y[idx]));
         hgap = (s.heading_tenths > hist_heading[idx])
                ? s.heading_tenths - hist_heading[idx] : hist_heading[idx] - s.heading_tenths;
         hgap = hgap % 3600;
         if (hgap > 1800) hgap = 3600 - hgap;
         if (dx * dx + dy * dy <= longint'(cfg_radius) * longint'(cfg_radius) &&
             hgap <= cfg_tol) begin
            case (hist_turn[idx])
               STEER_LEFT:  turn = STEER_RIGHT;
               STEER_RIGHT: turn = STEER_LEFT;
               default:     turn = STEER_STRAIGHT;
            endcase
            reason            = REASON_LOOP;
            hist_x[idx]       = s.pos_x_cm;
            hist_y[idx]       = s.pos_y_cm;
            hist_heading[idx] = s.heading_tenths;
            hist_turn[idx]    = turn;
            hit               = 1'b1;
         end
      end
      if (!hit) begin
         if (hist_count >= HISTORY_DEPTH) begin
            slot        = hist_oldest;
            hist_oldest = (hist_oldest + 1) % HISTORY_DEPTH;
         end else begin
            slot       = (hist_oldest + hist_count) % HISTORY_DEPTH;
            hist_count = hist_count + 1;
         end
         hist_x[slot]       = s.pos_x_cm;
         hist_y[slot]       = s.pos_y_cm;
         hist_heading[slot] = s.heading_tenths;
         hist_turn[slot]    = turn;
      end
      r.speed_pct   = cfg_decision;
      r.steer_dir   = turn;
      r.in_decision = 1'b1;
      r.reason_code = reason;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      otd_req_type scan;
      otd_rsp_type want, got;
      if (reset) begin
         cfg_trigger  = DIST_W'(30);
         cfg_corner   = DIST_W'(50);
         cfg_tie      = TIE_W'(26);
         cfg_radius   = RADIUS_W'(40);
         cfg_tol      = TOL_W'(300);
         cfg_cruise   = SPEED_W'(60);
         cfg_decision = SPEED_W'(30);
         hist_oldest  = 0;
         hist_count   = 0;
         steering_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_OBSTACLE_TRIGGER:  cfg_trigger  = csr_wdata[DIST_W-1:0];
               CSR_CORNER_DIVERGENCE: cfg_corner   = csr_wdata[DIST_W-1:0];
               CSR_TIE_FRACTION:      cfg_tie      = csr_wdata[TIE_W-1:0];
               CSR_LOOP_RADIUS:       cfg_radius   = csr_wdata[RADIUS_W-1:0];
               CSR_LOOP_HEADING_TOL:  cfg_tol      = csr_wdata[TOL_W-1:0];
               CSR_CRUISE_SPEED:      cfg_cruise   = csr_wdata[SPEED_W-1:0];
               CSR_DECISION_SPEED:    cfg_decision = csr_wdata[SPEED_W-1:0];
               default: ;
            endcase
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got.speed_pct   = rsp_if.speed_pct;
            got.steer_dir   = rsp_if.steer_dir;
            got.in_decision = rsp_if.in_decision;
            got.reason_code = rsp_if.reason_code;
            if (steering_q.size() == 0) begin
               $error("steering transaction with nothing expected: speed %0d steer %0d",
                      got.speed_pct, got.steer_dir);
               mismatch_count++;
            end else begin
               want = steering_q.pop_front();
               results_seen++;
               if (want.in_decision) decisions_seen++;
               if (want.reason_code == REASON_TIE) ties_seen++;
               if (want.reason_code == REASON_LOOP) loop_turns_seen++;
               if (got.speed_pct !== want.speed_pct) begin
                  $error("speed_pct: expected %0d, got %0d", want.speed_pct, got.speed_pct);
                  mismatch_count++;
               end
               if (got.steer_dir !== want.steer_dir) begin
                  $error("steer_dir: expected %0d, got %0d", want.steer_dir, got.steer_dir);
                  mismatch_count++;
               end
               if (got.in_decision !== want.in_decision) begin
                  $error("in_decision: expected %0d, got %0d",
                         want.in_decision, got.in_decision);
                  mismatch_count++;
               end
               if (got.reason_code !== want.reason_code) begin
                  $error("reason_code: expected %0d, got %0d",
                         want.reason_code, got.reason_code);
                  mismatch_count++;
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            scan.front_cm       = req_if.front_cm;
            scan.ir_front       = req_if.ir_front;
            scan.left45_cm      = req_if.left45_cm;
            scan.left90_cm      = req_if.left90_cm;
            scan.right45_cm     = req_if.right45_cm;
            scan.right90_cm     = req_if.right90_cm;
            scan.pos_x_cm       = req_if.pos_x_cm;
            scan.pos_y_cm       = req_if.pos_y_cm;
            scan.heading_tenths = req_if.heading_tenths;
            scan.coin_bit       = req_if.coin_bit;
            steering_q = {steering_q, predict_steering(scan)};
         end
      end
      pending <= steering_q.size();
   end

endmodule

FILE: tb/sv/obstacle_turn_decider_with_loop_memory_top_test.sv
// Stimulus and verdict for the obstacle turn decider with loop memory
`timescale 1ns / 1ps
module obstacle_turn_decider_with_loop_memory_top_test;
   import otd_pkg::*;

   localparam int SPOT_COUNT = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 3'd7;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int pending, mismatch_count, results_seen, decisions_seen, ties_seen, loop_turns_seen;
   int scans_sent;

   logic [POS_W-1:0]  spot_x [SPOT_COUNT];
   logic [POS_W-1:0]  spot_y [SPOT_COUNT];
   logic [HEAD_W-1:0] spot_hd [SPOT_COUNT];

   otd_req_if req_if ();
   otd_rsp_if rsp_if ();

   obstacle_turn_decider_with_loop_memory_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   otd_steer_check u_steer_check (
      .clock           (clock),
      .reset           (reset),
      .req_if          (req_if),
      .rsp_if          (rsp_if),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .pending         (pending),
      .mismatch_count  (mismatch_count),
      .results_seen    (results_seen),
      .decisions_seen  (decisions_seen),
      .ties_seen       (ties_seen),
      .loop_turns_seen (loop_turns_seen)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("Mismatches found");
      $finish;
   end

   // response side: random stalls, with calm stretches
   initial begin
      int hold, cycle;
      bit calm;
      hold  = 0;
      cycle = 0;
      calm  = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         cycle++;
         if (cycle % 256 == 0) calm = ($urandom_range(0, 3) == 0);
         if (hold > 0) begin
            rsp_if.ready <= 1'b0;
            hold--;
         end else begin
            rsp_if.ready <= 1'b1;
            if (!calm) begin
               case ($urandom_range(0, 99)) inside
                  [0:19]:  hold = $urandom_range(1, 3);
                  [20:21]: hold = $urandom_range(15, 60);
                  default: hold = 0;
               endcase
            end
         end
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] trigger, corner, tie, radius,
                            input logic [CSR_DATA_W-1:0] tol, cruise, decision);
      write_reg(CSR_OBSTACLE_TRIGGER, trigger);
      write_reg(CSR_CORNER_DIVERGENCE, corner);
      write_reg(CSR_TIE_FRACTION, tie);
      write_reg(CSR_LOOP_RADIUS, radius);
      write_reg(CSR_LOOP_HEADING_TOL, tol);
      write_reg(CSR_CRUISE_SPEED, cruise);
      write_reg(CSR_DECISION_SPEED, decision);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_scan(input otd_req_type s, input int gap);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.front_cm       <= s.front_cm;
      req_if.ir_front       <= s.ir_front;
      req_if.left45_cm      <= s.left45_cm;
      req_if.left90_cm      <= s.left90_cm;
      req_if.right45_cm     <= s.right45_cm;
      req_if.right90_cm     <= s.right90_cm;
      req_if.pos_x_cm       <= s.pos_x_cm;
      req_if.pos_y_cm       <= s.pos_y_cm;
      req_if.heading_tenths <= s.heading_tenths;
      req_if.coin_bit       <= s.coin_bit;
      do @(posedge clock); while (!req_if.ready);
      scans_sent++;
   endtask

   // hold off new scans until every steering result is back
   task automatic drain_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   function automatic otd_req_type scan_of(input int front, ir, l45, l90, r45, r90,
                                           input int x, y, hd, coin);
      otd_req_type s;
      s.front_cm       = RANGE_W'(front);
      s.ir_front       = 1'(ir);
      s.left45_cm      = RANGE_W'(l45);
      s.left90_cm      = RANGE_W'(l90);
      s.right45_cm     = RANGE_W'(r45);
      s.right90_cm     = RANGE_W'(r90);
      s.pos_x_cm       = POS_W'(x);
      s.pos_y_cm       = POS_W'(y);
      s.heading_tenths = HEAD_W'(hd);
      s.coin_bit       = 1'(coin);
      return s;
   endfunction

   function automatic otd_req_type random_scan();
      otd_req_type s;
      int roll, spot, reach, heading_v;
      roll = $urandom_range(0, 99);
      s.front_cm       = RANGE_W'($urandom);
      s.ir_front       = 1'($urandom);
      s.left45_cm      = RANGE_W'($urandom);
      s.left90_cm      = RANGE_W'($urandom);
      s.right45_cm     = RANGE_W'($urandom);
      s.right90_cm     = RANGE_W'($urandom);
      s.pos_x_cm       = POS_W'($urandom);
      s.pos_y_cm       = POS_W'($urandom);
      s.heading_tenths = HEAD_W'($urandom);
      s.coin_bit       = 1'($urandom);
      if (roll < 60) begin
         // revisit a known decision point
         spot  = $urandom_range(0, SPOT_COUNT - 1);
         reach = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 48);
         s.pos_x_cm = spot_x[spot] + POS_W'(int'($urandom_range(0, 2 * reach)) - reach);
         s.pos_y_cm = spot_y[spot] + POS_W'(int'($urandom_range(0, 2 * reach)) - reach);
         heading_v  = int'(spot_hd[spot]) + int'($urandom_range(0, 8 * reach)) - 4 * reach;
         if (heading_v < 0) heading_v += 3600;
         if (heading_v >= 3600) heading_v -= 3600;
         if (heading_v < 496 && $urandom_range(0, 7) == 0) heading_v += 3600;
         s.heading_tenths = HEAD_W'(heading_v);
         s.front_cm = RANGE_W'($urandom_range(0, 40));
         if ($urandom_range(0, 1) == 1) begin
            s.right45_cm = s.left45_cm + RANGE_W'($urandom_range(0, 12));
            s.right90_cm = s.left90_cm - RANGE_W'($urandom_range(0, 12));
         end
      end else if (roll < 85) begin
         if ($urandom_range(0, 19) == 0) begin
            s.left45_cm  = '0;
            s.left90_cm  = '0;
            s.right45_cm = '0;
            s.right90_cm = '0;
         end
      end else begin
         s.front_cm   = RANGE_W'($urandom_range(200, 1023));
         s.ir_front   = 1'b0;
         s.right90_cm = s.left90_cm;
      end
      return s;
   endfunction

   task automatic run_phase(input int count);
      int gap, roll;
      bit calm;
      calm = 1'b0;
      for (int n = 0; n < count; n++) begin
         if (n % 64 == 0) calm = ($urandom_range(0, 3) == 0);
         if (n == count / 2) drain_results();
         roll = $urandom_range(0, 99);
         if (calm || roll < 55) gap = 0;
         else if (roll < 92) gap = $urandom_range(1, 3);
         else gap = $urandom_range(10, 50);
         send_scan(random_scan(), gap);
      end
      drain_results();
   endtask

   initial begin
      scans_sent = 0;
      csr_wr_en <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_if.valid          <= 1'b0;
      req_if.front_cm       <= '0;
      req_if.ir_front       <= 1'b0;
      req_if.left45_cm      <= '0;
      req_if.left90_cm      <= '0;
      req_if.right45_cm     <= '0;
      req_if.right90_cm     <= '0;
      req_if.pos_x_cm       <= '0;
      req_if.pos_y_cm       <= '0;
      req_if.heading_tenths <= '0;
      req_if.coin_bit       <= 1'b0;
      for (int i = 0; i < SPOT_COUNT; i++) begin
         spot_x[i]  = POS_W'($urandom);
         spot_y[i]  = POS_W'($urandom);
         spot_hd[i] = HEAD_W'($urandom_range(0, 3599));
      end
      spot_x[0]  = 16'h7FFF;
      spot_y[0]  = 16'h7FFF;
      spot_hd[0] = '0;
      spot_x[1]  = 16'h8000;
      spot_y[1]  = 16'h8000;
      spot_hd[1] = HEAD_W'(3599);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed scans at the reset settings
      send_scan(scan_of(1023, 0, 100, 100, 100, 100, 0, 0, 0, 0), 0);
      send_scan(scan_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
      send_scan(scan_of(30, 0, 1023, 1023, 0, 0, 1000, 1000, 0, 0), 0);
      send_scan(scan_of(31, 1, 0, 0, 1023, 1023, -1000, -1000, 3599, 1), 0);
      send_scan(scan_of(1023, 0, 0, 50, 0, 0, 5000, 0, 0, 0), 0);
      send_scan(scan_of(1023, 0, 0, 0, 0, 49, 6000, 0, 0, 1), 0);
      send_scan(scan_of(10, 0, 100, 100, 100, 100, -5000, 5000, 1800, 0), 0);
      send_scan(scan_of(10, 0, 100, 95, 100, 100, -8000, 5000, 900, 1), 0);
      send_scan(scan_of(0, 0, 300, 300, 20, 20, 40, 0, 300, 0), 0);
      send_scan(scan_of(0, 0, 300, 300, 20, 20, 40, 41, 300, 0), 0);
      send_scan(scan_of(5, 0, 10, 10, 500, 500, 1000, 1000, 3500, 0), 0);
      send_scan(scan_of(5, 0, 10, 10, 500, 500, 5000, 0, 3800, 1), 0);
      send_scan(scan_of(0, 1, 1023, 1023, 1023, 1023, 32767, 32767, 4095, 1), 0);
      send_scan(scan_of(5, 0, 1023, 1023, 1023, 1022, -32768, -32768, 0, 0), 0);
      send_scan(scan_of(1023, 1, 200, 200, 200, 200, 20000, -20000, 1234, 0), 0);
      send_scan(scan_of(1023, 0, 1023, 1023, 1023, 1023, 0, 0, 0, 1), 0);
      send_scan(scan_of(0, 1, 0, 0, 0, 0, 32767, -32768, 4095, 1), 0);
      drain_results();

      configure(100, 200, 26, 60, 300, 100, 0);
      run_phase(240);
      configure(0, 0, 0, 0, 0, 0, 100);
      run_phase(240);
      configure(1023, 1023, 511, 4095, 2047, 127, 127);
      write_reg(CSR_UNUSED_INDEX, 12'hFFF);
      csr_wr_en <= 1'b0;
      run_phase(240);
      configure(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                CSR_DATA_W'($urandom), CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                CSR_DATA_W'($urandom));
      run_phase(240);
      configure(CSR_DATA_W'($urandom_range(0, 200)), CSR_DATA_W'($urandom_range(0, 300)),
                CSR_DATA_W'($urandom_range(0, 300)), CSR_DATA_W'($urandom_range(0, 120)),
                CSR_DATA_W'($urandom_range(0, 1800)), CSR_DATA_W'($urandom_range(0, 100)),
                CSR_DATA_W'($urandom_range(0, 100)));
      run_phase(240);
      configure(40, 60, 256, 30, 100, 50, 25);
      run_phase(240);

      repeat (60) @(posedge clock);
      if (pending != 0) $error("%0d steering results never arrived", pending);
      $display("Sent %0d scans: %0d decisions, %0d tie breaks, %0d loop reversals",
               scans_sent, decisions_seen, ties_seen, loop_turns_seen);
      $display("Registers swept through reset, low, high and random settings");
      if (mismatch_count == 0 && pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/otd_pkg.sv
rtl/otd_intf.sv
rtl/otd_dp.sv
rtl/otd_ctrl.sv
rtl/obstacle_turn_decider_with_loop_memory_top.sv
tb/sv/otd_steer_check.sv
tb/sv/obstacle_turn_decider_with_loop_memory_top_test.sv
